>>> hw/rtl/edf_priority_assigner_assert.svh
// Assertion macros for the EDF priority assigner.
// Included by the RTL top level, which carries the concurrent checks; no dependencies.
`ifndef EDF_PRIORITY_ASSIGNER_ASSERT_SVH
`define EDF_PRIORITY_ASSIGNER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define EDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("edf assertion failed");

// Check that a condition never holds outside reset.
`define EDF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("edf forbidden condition seen");

`else

`define EDF_ASSERT(lbl, clk, rst_n, prop)
`define EDF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/edf_pkg.sv
// Package of the EDF priority assigner: widths, reset values, register
// indexes and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  localparam int TaskCountDefault = 4;

  localparam int TimeW    = 32;
  localparam int PeriodW  = 16;
  localparam int PrioW    = 8;
  localparam int TaskIdW  = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int PeriodRegs = 4;

  localparam logic [PeriodW-1:0] Period0Reset = 16'd240;
  localparam logic [PeriodW-1:0] Period1Reset = 16'd480;
  localparam logic [PeriodW-1:0] Period2Reset = 16'd960;
  localparam logic [PeriodW-1:0] Period3Reset = 16'd1920;
  localparam logic [PrioW-1:0]   TopPrioReset = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD0  = 3'd0,
    REG_PERIOD1  = 3'd1,
    REG_PERIOD2  = 3'd2,
    REG_PERIOD3  = 3'd3,
    REG_TOP_PRIO = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP
  } state_e;

  // Result of the shared deadline unit
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic             earlier;
  } dl_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/edf_dl_unit.sv
// Shared deadline unit: adds a period to a release time (mod 2^32) and
// ranks the sum against a latched reference deadline. Uses edf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edf_dl_unit (
  input  logic [edf_pkg::TimeW-1:0]   release_i,
  input  logic [edf_pkg::PeriodW-1:0] period_i,
  input  logic [edf_pkg::TimeW-1:0]   ref_deadline_i,
  input  logic                        lower_index_i,
  output edf_pkg::dl_res_t            res_o
);
  import edf_pkg::*;

  logic [TimeW-1:0] sum;

  // Form the deadline, wrapping at 2^32
  assign sum = release_i + {{(TimeW-PeriodW){1'b0}}, period_i};

  // Earlier deadline, or equal deadline at a lower task index
  assign res_o.deadline = sum;
  assign res_o.earlier  = (sum < ref_deadline_i) ||
                          ((sum == ref_deadline_i) && lower_index_i);

endmodule

`default_nettype wire

>>> hw/rtl/edf_priority_assigner.sv
// Top level of the EDF priority assigner: configuration registers, release
// time store and the ranking sequencer. Uses edf_pkg and edf_dl_unit.
// A reschedule item keeps busy high while the sequencer ranks each task other than
// the caller; results strobe in task order, skipping the caller. The last one
// comes in the first cycle with busy low, or in busy's final cycle when the caller
// is the last task. Record-only items leave busy low. Throughput is set by the
// single shared add-and-compare unit, one deadline per cycle. Reset clears periods,
// top priority and release times to their defaults; results cannot be stalled by
// the receiver.
`timescale 1ns / 1ps
`default_nettype none

module edf_priority_assigner #(
  parameter int TASK_COUNT = edf_pkg::TaskCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [edf_pkg::TaskIdW-1:0]  caller_task_i,
  input  logic [edf_pkg::TimeW-1:0]    release_time_i,
  // results
  output logic                         out_strobe_o,
  output logic [edf_pkg::TaskIdW-1:0]  target_task_o,
  output logic [edf_pkg::PrioW-1:0]    new_priority_o,
  output logic                         last_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [edf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [edf_pkg::CfgDataW-1:0] cfg_data_i
);
  import edf_pkg::*;

  `include "edf_priority_assigner_assert.svh"

  localparam int TW = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;
  localparam logic [TW-1:0] LastTask = TW'(TASK_COUNT - 1);
  localparam logic [TW-1:0] PrevTask = TW'(TASK_COUNT - 2);

  logic [PeriodW-1:0] per_q [PeriodRegs];
  logic [PrioW-1:0]   top_q;
  logic [TimeW-1:0]   rel_q [TASK_COUNT];

  state_e             state_q, state_d;
  logic [TW-1:0]      t_q, t_d, k_q, k_d, rank_q, rank_d, caller_q, idx;
  logic [TimeW-1:0]   dt_q, dt_d;
  logic               strobe_q, strobe_d, last_q, last_d;
  logic [TaskIdW-1:0] target_q, target_d;
  logic [PrioW-1:0]   prio_q, prio_d;
  logic [TW-1:0]      rank_fin;
  logic [PrioW-1:0]   rank_ext;

  logic               accept, caller_ok, go;
  logic               t_is_caller, t_is_last, k_is_last;
  dl_res_t            unit_res;

  assign accept    = start && !busy;
  assign caller_ok = ({1'b0, caller_task_i} < (TaskIdW+1)'(TASK_COUNT));
  assign go        = accept && caller_ok && kind_i;

  assign t_is_caller = (t_q == caller_q);
  assign t_is_last   = (t_q == LastTask);
  assign k_is_last   = (k_q == LastTask);

  // Select which task the shared unit looks at
  assign idx = (state_q == ST_CMP) ? k_q : t_q;

  edf_dl_unit u_dl (
    .release_i      (rel_q[idx]),
    .period_i       (per_q[2'(idx)]),
    .ref_deadline_i (dt_q),
    .lower_index_i  (k_q < t_q),
    .res_o          (unit_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!t_is_caller) state_d = ST_CMP;
        else if (t_is_last) state_d = ST_IDLE;
      end
      ST_CMP: begin
        if (k_is_last) state_d = t_is_last ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rank_fin = rank_q + TW'(unit_res.earlier);
  assign rank_ext = PrioW'(rank_fin);

  // Datapath and result outputs
  always_comb begin
    t_d      = t_q;
    k_d      = k_q;
    rank_d   = rank_q;
    dt_d     = dt_q;
    strobe_d = 1'b0;
    target_d = target_q;
    prio_d   = prio_q;
    last_d   = last_q;
    case (state_q)
      ST_IDLE: begin
        if (go) t_d = '0;
      end
      ST_LOAD: begin
        if (t_is_caller) begin
          t_d = t_q + 1'b1;
        end else begin
          dt_d   = unit_res.deadline;
          k_d    = '0;
          rank_d = '0;
        end
      end
      ST_CMP: begin
        rank_d = rank_fin;
        k_d    = k_q + 1'b1;
        if (k_is_last) begin
          strobe_d = 1'b1;
          target_d = TaskIdW'(t_q);
          prio_d   = (top_q >= rank_ext) ? (top_q - rank_ext) : '0;
          last_d   = t_is_last || ((t_q == PrevTask) && (caller_q == LastTask));
          t_d      = t_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  // Sequencer payload
  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    k_q      <= k_d;
    rank_q   <= rank_d;
    dt_q     <= dt_d;
    target_q <= target_d;
    prio_q   <= prio_d;
    last_q   <= last_d;
    if (go) caller_q <= caller_task_i[TW-1:0];
  end

  // Store the caller's release time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_COUNT; i++) rel_q[i] <= '0;
    end else if (accept && caller_ok) begin
      rel_q[caller_task_i[TW-1:0]] <= release_time_i;
    end
  end

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q[0] <= Period0Reset;
      per_q[1] <= Period1Reset;
      per_q[2] <= Period2Reset;
      per_q[3] <= Period3Reset;
      top_q    <= TopPrioReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i inside {[REG_PERIOD0:REG_PERIOD3]}) begin
        per_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else if (cfg_index_i == REG_TOP_PRIO) begin
        top_q <= cfg_data_i[PrioW-1:0];
      end
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != ST_IDLE);
  assign out_strobe_o   = strobe_q;
  assign target_task_o  = target_q;
  assign new_priority_o = prio_q;
  assign last_o         = last_q;

  `EDF_ASSERT(a_strobe_after_cmp, clk_i, rst_ni, out_strobe_o |-> $past(state_q == ST_CMP && k_is_last))
  `EDF_ASSERT(a_go_busy, clk_i, rst_ni, go |=> busy)
  `EDF_ASSERT(a_rank_bound, clk_i, rst_ni, (state_q == ST_CMP) |-> (rank_q <= k_q))
  `EDF_ASSERT_NEVER(a_no_caller_result, clk_i, rst_ni, out_strobe_o && (target_q == TaskIdW'(caller_q)))
  `EDF_ASSERT(a_last_done, clk_i, rst_ni, (last_o && out_strobe_o) |-> (state_q != ST_CMP))

endmodule

`default_nettype wire

>>> sim/edf_priority_assigner_tb.sv
// Self-checking testbench for edf_priority_assigner: directed and random items
// with a deadline-ranking scoreboard. Depends on edf_pkg and the RTL top level.
`timescale 1ns / 1ps

module edf_priority_assigner_tb;
  import edf_pkg::*;

  localparam int NumTasks    = TaskCountDefault;
  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 9;
  localparam int DrainCycles = NumTasks * NumTasks + 8;
  localparam int CycleLimit  = 200000;
  localparam int RandPerSet  = 20;
  localparam int NumSettings = 6;
  localparam int MaxGap      = 18;
  localparam int MaxPrinted  = 40;

  // item kinds
  localparam logic KindRecord  = 1'b0;
  localparam logic KindResched = 1'b1;

  // register indexes that decode to nothing
  localparam int RegUnusedFirst = 5;
  localparam int RegUnusedLast  = 7;

  // idle patterns of the sender
  localparam int GapNone  = 0;
  localparam int GapAny   = 1;
  localparam int GapMixed = 2;

  typedef struct packed {
    logic [TaskIdW-1:0] target;
    logic [PrioW-1:0]   prio;
    logic               last;
  } prio_result_t;

  // Deadline ranking predictor with its own copy of periods and release times
  class edf_rank_scoreboard;
    logic [PeriodW-1:0] periods[NumTasks];
    logic [PrioW-1:0]   top_prio;
    logic [TimeW-1:0]   release_t[NumTasks];
    prio_result_t       pending[$];
    int unsigned        fail_count;

    function new();
      periods[0] = Period0Reset;
      periods[1] = Period1Reset;
      periods[2] = Period2Reset;
      periods[3] = Period3Reset;
      top_prio   = TopPrioReset;
      foreach (release_t[k]) release_t[k] = '0;
      fail_count = 0;
    endfunction

    task report(input string msg);
      if (fail_count < MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
    endtask

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      if (idx <= REG_PERIOD3) periods[idx] = data[PeriodW-1:0];
      else if (idx == REG_TOP_PRIO) top_prio = data[PrioW-1:0];
    endfunction

    // Store the release time and, on a reschedule, queue one priority per other task
    function void note_item(input logic kind, input logic [TaskIdW-1:0] caller,
                            input logic [TimeW-1:0] rel);
      logic [TimeW-1:0] dl[NumTasks];
      prio_result_t     r;
      int               rank;
      int               prio;
      int               last_t;
      if (int'(caller) >= NumTasks) return;
      release_t[caller] = rel;
      if (kind == KindRecord) return;
      for (int k = 0; k < NumTasks; k++) dl[k] = release_t[k] + 32'(periods[k]);
      last_t = (int'(caller) == NumTasks - 1) ? NumTasks - 2 : NumTasks - 1;
      for (int t = 0; t < NumTasks; t++) begin
        if (t == int'(caller)) continue;
        rank = 0;
        for (int k = 0; k < NumTasks; k++) begin
          if (dl[k] < dl[t] || (dl[k] == dl[t] && k < t)) rank++;
        end
        prio = (int'(top_prio) >= rank) ? int'(top_prio) - rank : 0;
        r.target = TaskIdW'(t);
        r.prio   = PrioW'(prio);
        r.last   = (t == last_t);
        pending.push_back(r);
      end
    endfunction

    task check_result(input logic [TaskIdW-1:0] target, input logic [PrioW-1:0] prio,
                      input logic last);
      prio_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result task=%0d prio=%0d last=%0b", target, prio, last));
        return;
      end
      want = pending.pop_front();
      if (target !== want.target || prio !== want.prio || last !== want.last)
        report($sformatf("got task=%0d prio=%0d last=%0b, want task=%0d prio=%0d last=%0b",
                         target, prio, last, want.target, want.prio, want.last));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                kind_i;
  logic [TaskIdW-1:0]  caller_task_i;
  logic [TimeW-1:0]    release_time_i;
  logic                out_strobe_o;
  logic [TaskIdW-1:0]  target_task_o;
  logic [PrioW-1:0]    new_priority_o;
  logic                last_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  edf_rank_scoreboard sb;
  int unsigned        cycle_count = 0;
  logic [TimeW-1:0]   tie_base;

  edf_priority_assigner #(
    .TASK_COUNT(NumTasks)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .caller_task_i (caller_task_i),
    .release_time_i(release_time_i),
    .out_strobe_o  (out_strobe_o),
    .target_task_o (target_task_o),
    .new_priority_o(new_priority_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Check every strobed result against the oldest expected priority
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) sb.check_result(target_task_o, new_priority_o, last_o);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      GapNone: return 0;
      GapAny:  return $urandom_range(0, MaxGap);
      default: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MaxGap);
    endcase
  endfunction

  // Idle with start low for the gap, then hold start until the block takes the item
  task automatic send_item(input logic kind, input logic [TaskIdW-1:0] caller,
                           input logic [TimeW-1:0] rel, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start          <= 1'b1;
    kind_i         <= kind;
    caller_task_i  <= caller;
    release_time_i <= rel;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(kind, caller, rel);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop start and hold off until every expected priority has come back
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_periods(input logic [CfgDataW-1:0] data, input bit randomize);
    for (int k = 0; k < NumTasks; k++)
      write_cfg(CfgIdxW'(int'(REG_PERIOD0) + k), randomize ? CfgDataW'($urandom) : data);
  endtask

  task automatic apply_setting(input int which);
    case (which)
      0: begin
        write_periods(16'hFFFF, 1'b0);
        write_cfg(REG_TOP_PRIO, 16'hA5FE);
        for (int u = RegUnusedFirst; u <= RegUnusedLast; u++)
          write_cfg(CfgIdxW'(u), CfgDataW'($urandom));
      end
      1: begin
        // zero periods and zero top priority: deadlines equal release times, all saturate
        write_periods(16'h0000, 1'b0);
        write_cfg(REG_TOP_PRIO, 16'h0000);
      end
      2: begin
        write_periods(16'h0001, 1'b0);
        write_cfg(REG_TOP_PRIO, 16'hFFFF);
      end
      3: begin
        write_periods('0, 1'b1);
        write_cfg(REG_TOP_PRIO, CfgDataW'($urandom));
      end
      4: begin
        // equal periods make deadline ties common; a top of one saturates at zero for later ranks
        write_periods(16'd1000, 1'b0);
        write_cfg(REG_TOP_PRIO, 16'h0001);
      end
      default: begin
        write_cfg(REG_PERIOD0, Period0Reset);
        write_cfg(REG_PERIOD1, Period1Reset);
        write_cfg(REG_PERIOD2, Period2Reset);
        write_cfg(REG_PERIOD3, Period3Reset);
        write_cfg(REG_TOP_PRIO, 16'h0003);
      end
    endcase
  endtask

  // Random item: mostly reschedules, release times aimed at ties and wrap-around
  task automatic send_random(input int gap_mode);
    logic               kind;
    logic [TaskIdW-1:0] caller;
    logic [TimeW-1:0]   rel;
    kind   = ($urandom_range(0, 9) < 7) ? KindResched : KindRecord;
    caller = TaskIdW'($urandom_range(0, NumTasks - 1));
    case ($urandom_range(0, 3))
      0: rel = $urandom;
      1: rel = $urandom_range(0, 4095);
      2: rel = tie_base - 32'(sb.periods[caller]) + $urandom_range(0, 1);
      default: rel = 32'hFFFF_FFFF - $urandom_range(0, 70000);
    endcase
    send_item(kind, caller, rel, draw_gap(gap_mode));
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    kind_i         = 1'b0;
    caller_task_i  = '0;
    release_time_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    tie_base       = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at reset periods: extremes, record only, wrap, ties
    send_item(KindResched, 2'd0, 32'h0000_0000, draw_gap(GapMixed));
    send_item(KindRecord,  2'd1, 32'hFFFF_FFFF, draw_gap(GapMixed));
    send_item(KindResched, 2'd2, 32'hAAAA_AAAA, draw_gap(GapMixed));
    send_item(KindResched, 2'd3, 32'h5555_5555, draw_gap(GapMixed));
    send_item(KindResched, 2'd1, 32'hFFFF_FFFF, draw_gap(GapMixed));
    // every deadline at 1000: ranks follow task index
    send_item(KindRecord,  2'd0, 32'd760, 0);
    send_item(KindRecord,  2'd1, 32'd520, 0);
    send_item(KindRecord,  2'd2, 32'd40, 0);
    send_item(KindResched, 2'd3, 32'hFFFF_FC68, 0);
    send_item(KindResched, 2'd0, 32'd760, draw_gap(GapMixed));
    send_item(KindResched, 2'd1, 32'd520, draw_gap(GapMixed));
    send_item(KindResched, 2'd2, 32'd40, draw_gap(GapMixed));
    send_item(KindRecord,  2'd3, 32'h0000_0000, draw_gap(GapMixed));
    send_item(KindResched, 2'd0, 32'hFFFF_FFFF, draw_gap(GapMixed));
    settle();

    // Random phases, one per register setting, idle pattern rotating
    for (int s = 0; s < NumSettings; s++) begin
      apply_setting(s);
      tie_base = $urandom;
      for (int i = 0; i < RandPerSet; i++) send_random(s % 3);
      settle();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never came", sb.pending.size()));
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
